// ----- rtl/srws_pkg.sv -----
// Shared constants, item codes and controller/datapath interface types.
package srws_pkg;

  // Store geometry and sample format.
  localparam int unsigned DEPTH       = 4096;
  localparam int unsigned ADDR_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W       = ADDR_W + 1;
  localparam int unsigned SMP_W       = 12;
  localparam int unsigned SUM_W       = SMP_W + ADDR_W;

  // Frequency scaling: freq = transitions * SAMPLE_RATE / (2 * DEPTH).
  localparam int unsigned SAMPLE_RATE = 525000;
  localparam int unsigned RATE_W      = $clog2(SAMPLE_RATE + 1);
  localparam int unsigned PROD_W      = ADDR_W + RATE_W;
  localparam int unsigned FREQ_W      = 19;
  localparam int unsigned FREQ_MAX    = (1 << FREQ_W) - 1;
  localparam int unsigned QUOT_W      = PROD_W - ADDR_W - 1;

  localparam int unsigned MODE_W      = 3;
  localparam logic [SMP_W-1:0] THRESH_RESET = SMP_W'(2048);

  // Item codes carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_SAMPLE  = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_FREEZE  = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_READ    = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_RELEASE = MODE_W'(3);
  localparam logic [MODE_W-1:0] MODE_STATS   = MODE_W'(4);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_wr;    // write zero at the sweep counter
    logic smp_wr;      // store a sample unless frozen
    logic freeze;      // latch oldest position, stop capture
    logic release_cap; // resume capture
    logic rd_issue;    // read the store at oldest + index
    logic rd_capture;  // take read data as a result
    logic walk_start;  // clear the statistics accumulators
    logic walk_issue;  // read the store at the sweep counter
    logic mul;         // register transitions * sample rate
    logic scale;       // form frequency and mean results
    logic load_out;    // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_done;    // sweep counter has covered the whole store
    logic out_free;    // output register can take a result this cycle
  } status_t;

endpackage

// ----- rtl/srws_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module srws_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/srws_ctrl.sv -----
// Controller state machine: sequences clearing, capture, reads and statistics.
module srws_ctrl
  import srws_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [MODE_W-1:0] mode_i,
  input  status_t           status_i,
  output cmd_t              cmd_o
);

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_RD    = 8'b0000_0100,
    ST_WALK  = 8'b0000_1000,
    ST_MUL   = 8'b0001_0000,
    ST_SCALE = 8'b0010_0000,
    ST_PEND  = 8'b0100_0000,
    ST_SPARE = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // Items are taken only while waiting in the idle state.
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.cnt_done) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.clear_wr = 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (mode_i)
            MODE_SAMPLE:  cmd_o.smp_wr      = 1'b1;
            MODE_FREEZE:  cmd_o.freeze      = 1'b1;
            MODE_RELEASE: cmd_o.release_cap = 1'b1;
            MODE_READ: begin
              cmd_o.rd_issue = 1'b1;
              state_d        = ST_RD;
            end
            MODE_STATS: begin
              cmd_o.walk_start = 1'b1;
              state_d          = ST_WALK;
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        cmd_o.rd_capture = 1'b1;
        state_d          = ST_PEND;
      end
      ST_WALK: begin
        // The last read's data is accumulated in the cycle that sees the end.
        if (status_i.cnt_done) begin
          state_d = ST_MUL;
        end else begin
          cmd_o.walk_issue = 1'b1;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_PEND;
      end
      ST_PEND: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/srws_dpath.sv -----
// Datapath: sample store, pointers, statistics accumulators and output register.
module srws_dpath
  import srws_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  input  logic              cfg_we_i,
  input  logic [SMP_W-1:0]  cfg_wdata_i,
  input  logic [SMP_W-1:0]  sample_i,
  input  logic [SMP_W-1:0]  read_index_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SMP_W-1:0]  read_value_o,
  output logic [FREQ_W-1:0] freq_hz_o,
  output logic [SMP_W-1:0]  mean_level_o
);

  logic [SMP_W-1:0]  thresh_q;
  logic [ADDR_W-1:0] wr_pos_q, wr_pos_d;
  logic [ADDR_W-1:0] oldest_q;
  logic              frozen_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              dv_q;
  logic              first_q;
  logic              prev_q;
  logic [SUM_W-1:0]  sum_q;
  logic [ADDR_W-1:0] trans_q;
  logic [PROD_W-1:0] prod_q;
  logic [SMP_W-1:0]  res_rv_q;
  logic [FREQ_W-1:0] res_freq_q;
  logic [SMP_W-1:0]  res_mean_q;
  logic              out_valid_q;
  logic [SMP_W-1:0]  out_rv_q;
  logic [FREQ_W-1:0] out_freq_q;
  logic [SMP_W-1:0]  out_mean_q;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [SMP_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [SMP_W-1:0]  ram_rdata;
  logic              smp_store;
  logic              level_hi;
  logic [QUOT_W-1:0] quot;
  logic [FREQ_W-1:0] freq_sat;

  // Store port selection: clearing sweep or sample capture on the write side,
  // chronological read or statistics sweep on the read side.
  assign smp_store = cmd_i.smp_wr && !frozen_q;
  assign ram_we    = cmd_i.clear_wr || smp_store;
  assign ram_waddr = cmd_i.clear_wr ? cnt_q[ADDR_W-1:0] : wr_pos_q;
  assign ram_wdata = cmd_i.clear_wr ? '0 : sample_i;
  assign ram_re    = cmd_i.rd_issue || cmd_i.walk_issue;
  assign ram_raddr = cmd_i.rd_issue ? ADDR_W'(oldest_q + read_index_i[ADDR_W-1:0])
                                    : cnt_q[ADDR_W-1:0];
  assign wr_pos_d  = ADDR_W'(wr_pos_q + 1'b1);

  srws_ram #(
    .WIDTH (SMP_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Configuration, pointers, freeze flag and sweep counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
      wr_pos_q <= '0;
      oldest_q <= '0;
      frozen_q <= 1'b0;
      cnt_q    <= '0;
      dv_q     <= 1'b0;
      first_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thresh_q <= cfg_wdata_i;
      end
      if (smp_store) begin
        wr_pos_q <= wr_pos_d;
      end
      if (cmd_i.freeze) begin
        frozen_q <= 1'b1;
        oldest_q <= wr_pos_q;
      end
      if (cmd_i.release_cap) begin
        frozen_q <= 1'b0;
      end
      if (cmd_i.walk_start) begin
        cnt_q <= '0;
      end else if (cmd_i.clear_wr || cmd_i.walk_issue) begin
        cnt_q <= CNT_W'(cnt_q + 1'b1);
      end
      dv_q <= cmd_i.walk_issue;
      if (cmd_i.walk_start) begin
        first_q <= 1'b1;
      end else if (dv_q) begin
        first_q <= 1'b0;
      end
    end
  end

  // Statistics accumulation: one store entry per cycle as read data returns.
  // The first entry only seeds the previous level.
  assign level_hi = (ram_rdata >= thresh_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_start) begin
      sum_q   <= '0;
      trans_q <= '0;
    end else if (dv_q) begin
      sum_q  <= SUM_W'(sum_q + SUM_W'(ram_rdata));
      prev_q <= level_hi;
      if (!first_q && (level_hi != prev_q)) begin
        trans_q <= ADDR_W'(trans_q + 1'b1);
      end
    end
  end

  // Frequency scaling: one constant multiply, then a division by 2*DEPTH as a shift.
  assign quot     = prod_q[PROD_W-1:ADDR_W+1];
  assign freq_sat = (32'(quot) > FREQ_MAX) ? FREQ_W'(FREQ_MAX) : FREQ_W'(quot);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(trans_q) * PROD_W'(SAMPLE_RATE);
    end
    if (cmd_i.rd_capture) begin
      res_rv_q   <= ram_rdata;
      res_freq_q <= '0;
      res_mean_q <= '0;
    end else if (cmd_i.scale) begin
      res_rv_q   <= '0;
      res_freq_q <= freq_sat;
      res_mean_q <= sum_q[SUM_W-1:ADDR_W];
    end
  end

  // Output register: holds a result until its transaction completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_rv_q   <= res_rv_q;
      out_freq_q <= res_freq_q;
      out_mean_q <= res_mean_q;
    end
  end

  assign status_o.cnt_done = cnt_q[ADDR_W];
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_rv_q;
  assign freq_hz_o    = out_freq_q;
  assign mean_level_o = out_mean_q;

endmodule

// ----- rtl/sample_ring_window_stats_core.sv -----
// Top level of the sample ring with read-back and window statistics.
// After reset the block sweeps its 4096-entry sample store to zero; during that
// time in_stall_o is high (threshold writes are still taken). A sample, freeze or
// release transaction is taken without leaving the idle state, so samples may
// arrive back to back. A read transaction occupies the block through its issue,
// store read and output load steps, and a stats transaction through a sweep of
// the single store read port over every entry once, followed by a step for the
// last read data, one multiply, one scaling and one output load step.
// A finished result waits in the output register if the consumer stalls, and
// the block takes no further item until that result has been loaded there.
module sample_ring_window_stats_core
  import srws_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SMP_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [SMP_W-1:0]  sample_i,
  input  logic [SMP_W-1:0]  read_index_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SMP_W-1:0]  read_value_o,
  output logic [FREQ_W-1:0] freq_hz_o,
  output logic [SMP_W-1:0]  mean_level_o
);

  cmd_t    cmd;
  status_t status;

  // Sequencing of transactions.
  srws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Store, pointers, arithmetic and output register.
  srws_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .sample_i     (sample_i),
    .read_index_i (read_index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_value_o (read_value_o),
    .freq_hz_o    (freq_hz_o),
    .mean_level_o (mean_level_o)
  );

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the sample ring with read-back and window statistics.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srws_pkg::*;

  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 175;
  localparam logic [MODE_W-1:0] MODE_TOP = {MODE_W{1'b1}};

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SMP_W-1:0]  sample;
    logic [SMP_W-1:0]  read_index;
  } ring_item_t;

  typedef struct packed {
    logic [SMP_W-1:0]  read_value;
    logic [FREQ_W-1:0] freq_hz;
    logic [SMP_W-1:0]  mean_level;
  } ring_result_t;

  // Clock, reset and the block's ports.
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [SMP_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [MODE_W-1:0] mode = '0;
  logic [SMP_W-1:0]  sample = '0;
  logic [SMP_W-1:0]  read_index = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [SMP_W-1:0]  read_value;
  logic [FREQ_W-1:0] freq_hz;
  logic [SMP_W-1:0]  mean_level;

  // Shadow copy of the ring state and the threshold register.
  logic [SMP_W-1:0]  ring_store [DEPTH];
  logic [ADDR_W-1:0] ring_wr_ptr;
  logic [ADDR_W-1:0] ring_oldest;
  bit                ring_frozen;
  logic [SMP_W-1:0]  ring_thresh;

  ring_item_t   item_q[$];
  ring_result_t due_results[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          pressure_armed;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned n_planned;
  int unsigned n_taken;
  int unsigned n_reads;
  int unsigned n_stats;
  int unsigned n_errors;
  logic [SMP_W-1:0] last_thresh;

  sample_ring_window_stats_core u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .mode_i       (mode),
    .sample_i     (sample),
    .read_index_i (read_index),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .read_value_o (read_value),
    .freq_hz_o    (freq_hz),
    .mean_level_o (mean_level)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Walk the whole store in physical order: floored mean and level-change frequency.
  function automatic ring_result_t window_stats();
    ring_result_t     r;
    longint unsigned  sum;
    longint unsigned  trans;
    longint unsigned  f;
    bit               prev;
    bit               lvl;
    r = '0;
    sum = 0;
    trans = 0;
    prev = (ring_store[0] >= ring_thresh);
    for (int i = 0; i < DEPTH; i++) begin
      lvl = (ring_store[i] >= ring_thresh);
      sum += ring_store[i];
      if (lvl != prev) trans++;
      prev = lvl;
    end
    f = (trans * SAMPLE_RATE) / (2 * DEPTH);
    if (f > FREQ_MAX) f = FREQ_MAX;
    r.freq_hz = FREQ_W'(f);
    r.mean_level = SMP_W'(sum / DEPTH);
    return r;
  endfunction

  // Advance the shadow ring by one accepted transaction and queue any result it causes.
  function automatic void predict_ring_item(ring_item_t it);
    ring_result_t      r;
    logic [ADDR_W-1:0] pos;
    r = '0;
    case (it.mode)
      MODE_SAMPLE: begin
        if (!ring_frozen) begin
          ring_store[ring_wr_ptr] = it.sample;
          ring_wr_ptr = ring_wr_ptr + 1'b1;
        end
      end
      MODE_FREEZE: begin
        ring_frozen = 1'b1;
        ring_oldest = ring_wr_ptr;
      end
      MODE_READ: begin
        pos = ring_oldest + it.read_index;
        r.read_value = ring_store[pos];
        due_results.push_back(r);
        n_reads++;
      end
      MODE_RELEASE: begin
        ring_frozen = 1'b0;
      end
      MODE_STATS: begin
        due_results.push_back(window_stats());
        n_stats++;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void plan_item(logic [MODE_W-1:0] m, logic [SMP_W-1:0] s,
                                    logic [SMP_W-1:0] ri);
    ring_item_t it;
    it.mode = m;
    it.sample = s;
    it.read_index = ri;
    item_q.push_back(it);
    if (m <= MODE_STATS) n_planned++;
  endfunction

  function automatic logic [SMP_W-1:0] rand_word();
    return SMP_W'($urandom);
  endfunction

  // Indexes near the oldest entry, near the newest one, or anywhere.
  function automatic logic [SMP_W-1:0] pick_read_index();
    case ($urandom_range(2))
      0: return SMP_W'($urandom_range(15));
      1: return SMP_W'(DEPTH - 1 - $urandom_range(15));
      default: return rand_word();
    endcase
  endfunction

  // Capture a burst, freeze, read it back and release; sometimes broken or with extras.
  function automatic void plan_capture_session();
    int unsigned n_smp;
    int unsigned n_rd;
    n_smp = ($urandom_range(7) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1);
    n_rd = $urandom_range(4, 1);
    for (int i = 0; i < n_smp; i++) plan_item(MODE_SAMPLE, rand_word(), rand_word());
    plan_item(MODE_FREEZE, rand_word(), rand_word());
    if ($urandom_range(3) == 0) plan_item(MODE_FREEZE, rand_word(), rand_word());
    for (int i = 0; i < n_rd; i++) begin
      plan_item(MODE_READ, rand_word(), pick_read_index());
      if ($urandom_range(3) == 0) plan_item(MODE_SAMPLE, rand_word(), rand_word());
    end
    if ($urandom_range(5) == 0) plan_item(MODE_STATS, rand_word(), rand_word());
    if ($urandom_range(7) != 0) plan_item(MODE_RELEASE, rand_word(), rand_word());
  endfunction

  function automatic void plan_random(int unsigned n_items);
    int unsigned goal;
    int unsigned roll;
    goal = n_planned + n_items;
    while (n_planned < goal) begin
      roll = $urandom_range(99);
      if (roll < 68) begin
        plan_capture_session();
      end else if (roll < 82) begin
        plan_item(MODE_STATS, rand_word(), rand_word());
      end else if (roll < 88) begin
        plan_item(MODE_W'($urandom_range(MODE_TOP, MODE_STATS + 1)), rand_word(),
                  rand_word());
      end else begin
        plan_item(MODE_W'($urandom_range(MODE_TOP)), rand_word(), pick_read_index());
      end
    end
  endfunction

  // Field extremes, threshold edges, every item code and the corner cases.
  function automatic void plan_directed();
    plan_item(MODE_STATS, '0, '1);
    plan_item(MODE_SAMPLE, '0, '1);
    plan_item(MODE_SAMPLE, '1, '0);
    plan_item(MODE_SAMPLE, 12'hAAA, 12'h555);
    plan_item(MODE_SAMPLE, 12'h555, 12'hAAA);
    plan_item(MODE_SAMPLE, THRESH_RESET - 1'b1, '0);
    plan_item(MODE_SAMPLE, THRESH_RESET, '0);
    // Read before any freeze uses the oldest position from reset.
    plan_item(MODE_READ, '1, '0);
    plan_item(MODE_RELEASE, '1, '1);
    plan_item(MODE_FREEZE, '0, '0);
    plan_item(MODE_FREEZE, '1, '1);
    // Dropped while frozen.
    plan_item(MODE_SAMPLE, '1, '1);
    plan_item(MODE_READ, '0, '0);
    plan_item(MODE_READ, '0, '1);
    plan_item(MODE_READ, '0, SMP_W'(DEPTH - 6));
    plan_item(MODE_READ, '0, 12'd1);
    plan_item(MODE_STATS, '0, '0);
    plan_item(MODE_RELEASE, '0, '0);
    plan_item(MODE_SAMPLE, 12'h800, '0);
    // Read while capture runs again.
    plan_item(MODE_READ, '0, '1);
    for (int m = MODE_STATS + 1; m <= MODE_TOP; m++) plan_item(MODE_W'(m), '1, '1);
    plan_item(MODE_STATS, '1, '0);
  endfunction

  function automatic void report_error(string msg);
    n_errors++;
    if (n_errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Block until every planned transaction is taken and every result has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (item_q.size() != 0 || in_valid || due_results.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_threshold(logic [SMP_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    ring_thresh = v;
    last_thresh = v;
    @(negedge clk);
  endtask

  // Driver: offers queued items and updates the shadow ring on each accepted transaction.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_ring_item('{mode, sample, read_index});
        n_taken++;
      end
      if (in_valid && in_stall) begin
        // Hold the stalled transaction unchanged.
      end else if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        mode <= item_q[0].mode;
        sample <= item_q[0].sample;
        read_index <= item_q[0].read_index;
        void'(item_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transaction and drives the consumer stall.
  always @(posedge clk or negedge rst_n) begin
    ring_result_t got;
    ring_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{read_value, freq_hz, mean_level};
        if (due_results.size() == 0) begin
          report_error($sformatf("unexpected result rd=%0d freq=%0d mean=%0d",
                                 got.read_value, got.freq_hz, got.mean_level));
        end else begin
          want = due_results.pop_front();
          if (got.read_value !== want.read_value || got.freq_hz !== want.freq_hz ||
              got.mean_level !== want.mean_level) begin
            report_error($sformatf(
              "result exp rd=%0d freq=%0d mean=%0d, got rd=%0d freq=%0d mean=%0d",
              want.read_value, want.freq_hz, want.mean_level,
              got.read_value, got.freq_hz, got.mean_level));
          end
        end
        // Long back-pressure so the block fills up and stalls its input.
        if (pressure_armed) begin
          pressure_armed = 1'b0;
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any transaction on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sequencer: reset, then phases with different thresholds and idle mixes.
  initial begin
    foreach (ring_store[i]) ring_store[i] = '0;
    ring_wr_ptr = '0;
    ring_oldest = '0;
    ring_frozen = 1'b0;
    ring_thresh = THRESH_RESET;
    last_thresh = THRESH_RESET;
    send_idle_pct = 6;
    recv_idle_pct = 79;
    pressure_armed = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    plan_directed();
    wait_drained();

    write_threshold('0);
    plan_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 79;
    recv_idle_pct = 6;
    write_threshold('1);
    plan_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    pressure_armed = 1'b1;
    write_threshold(SMP_W'($urandom_range(4094, 1)));
    plan_random(PHASE_ITEMS);
    wait_drained();
    repeat (20) @(negedge clk);

    $display("Run covered %0d input transactions, %0d read-backs and %0d window stats.",
             n_taken, n_reads, n_stats);
    $display("Thresholds: reset value, 0, 4095 and %0d; idle mixes sender, receiver, none.",
             last_thresh);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches in total", n_errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/srws_pkg.sv
rtl/srws_ram.sv
rtl/srws_ctrl.sv
rtl/srws_dpath.sv
rtl/sample_ring_window_stats_core.sv
bench/tb.sv
